// ===== design/psg3t1n_pkg.sv =====
`default_nettype none

package psg3t1n_pkg;

    // Tone channels that are ticked and mixed (the register map always holds three)
    localparam int TONE_CHANNELS = 3;
    localparam int TONE_REGS     = 3;

    // Field and register widths
    localparam int PERIOD_W = 10;
    localparam int COUNT_W  = 11;
    localparam int ATTEN_W  = 4;
    localparam int LFSR_W   = 15;
    localparam int CLOCK_W  = 23;
    localparam int RATE_W   = 18;
    localparam int THRESH_W = 22;
    localparam int ACC_W    = 25;
    localparam int LEVEL_W  = 13;
    localparam int SUM_W    = 17;
    localparam int SAMPLE_W = 14;
    localparam int CFG_W    = 23;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_CLOCK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b1;

    localparam logic [CLOCK_W-1:0] CHIP_CLOCK_RESET  = 23'd3546900;
    localparam logic [RATE_W-1:0]  SAMPLE_RATE_RESET = 18'd48000;

    // Chip register map codes
    localparam logic [2:0] REG_NOISE_MODE = 3'd6;

    // Input actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [LFSR_W-1:0]  LFSR_SEED     = 15'h4000;
    localparam logic [COUNT_W-1:0] TONE_CD_RESET = 11'h400;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_MIX,
        ST_OUT
    } psg_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic bus_write;
        logic acc_add;
        logic tick;
        logic mix;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mute;
        logic tick_due;
        logic out_free;
    } dp_sts_t;

    // Period register of zero acts as the longest period
    function automatic logic [COUNT_W-1:0] period_or_max(input logic [PERIOD_W-1:0] p);
        period_or_max = (p == '0) ? TONE_CD_RESET : {1'b0, p};
    endfunction

    function automatic logic [COUNT_W-1:0] noise_cd_load(input logic [1:0] mode,
                                                         input logic [PERIOD_W-1:0] tone2);
        case (mode)
            2'd0:    noise_cd_load = 11'h010;
            2'd1:    noise_cd_load = 11'h020;
            2'd2:    noise_cd_load = 11'h040;
            default: noise_cd_load = period_or_max(tone2);
        endcase
    endfunction

    // 2 dB attenuation steps, code 15 is silent
    function automatic logic [LEVEL_W-1:0] atten_level(input logic [ATTEN_W-1:0] code);
        case (code)
            4'd0:    atten_level = 13'd8191;
            4'd1:    atten_level = 13'd6506;
            4'd2:    atten_level = 13'd5168;
            4'd3:    atten_level = 13'd4105;
            4'd4:    atten_level = 13'd3261;
            4'd5:    atten_level = 13'd2590;
            4'd6:    atten_level = 13'd2057;
            4'd7:    atten_level = 13'd1634;
            4'd8:    atten_level = 13'd1298;
            4'd9:    atten_level = 13'd1031;
            4'd10:   atten_level = 13'd819;
            4'd11:   atten_level = 13'd650;
            4'd12:   atten_level = 13'd516;
            4'd13:   atten_level = 13'd410;
            4'd14:   atten_level = 13'd326;
            default: atten_level = 13'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== design/psg_three_tone_one_noise.sv =====
// Bus write: taken while idle; the next item is taken in the following cycle.
// Sample request: ST_ADD, then ST_TICK for N = ticks owed, one tick per cycle
// (about clock / (16 * rate), e.g. 4 or 5 at the reset settings), then ST_MIX, ST_OUT;
// when muted, only ST_MIX and ST_OUT. Input stalls until the output register is free.
// Reset (rst_n, asynchronous, active low) restores the chip registers and
// configuration to their power-on values and empties the output register.
`default_nettype none

module psg_three_tone_one_noise
    import psg3t1n_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  action,
    input  wire logic [7:0]            write_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [SAMPLE_W-1:0] sample_value
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequence each transfer
    psg3t1n_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold chip state, tick and mix
    psg3t1n_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .write_byte   (write_byte),
        .cmd          (cmd),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .sample_value (sample_value)
    );

endmodule

`default_nettype wire

// ===== design/psg3t1n_ctrl.sv =====
`default_nettype none

module psg3t1n_ctrl
    import psg3t1n_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    action,
    output logic         in_stall,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    psg_state_t state_reg;
    psg_state_t state_next;
    logic       in_xfer;

    assign in_xfer = in_valid && (state_reg == ST_IDLE);

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (action == ACT_SAMPLE))
                begin
                    state_next = sts.mute ? ST_MIX : ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = ST_TICK;
            end
            ST_TICK:
            begin
                if (!sts.tick_due)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands and the input stall
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE: cmd.bus_write = in_xfer && (action == ACT_WRITE);
            ST_ADD:  cmd.acc_add   = 1'b1;
            ST_TICK: cmd.tick      = sts.tick_due;
            ST_MIX:  cmd.mix       = 1'b1;
            ST_OUT:  cmd.load_out  = sts.out_free;
            default: cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && !sts.tick_due) |=> (state_reg == ST_MIX))
        else $error("tick phase did not hand over to mixing");

    a_sample_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && action == ACT_SAMPLE) |=> (state_reg != ST_IDLE))
        else $error("sample request transfer did not start work");
`endif

endmodule

`default_nettype wire

// ===== design/psg3t1n_dp.sv =====
`default_nettype none

module psg3t1n_dp
    import psg3t1n_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [7:0]           write_byte,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic signed [SAMPLE_W-1:0] sample_value
);

    logic [CLOCK_W-1:0]  clock_reg;
    logic [RATE_W-1:0]   rate_reg;

    logic [PERIOD_W-1:0] period_reg  [TONE_REGS];
    logic [PERIOD_W-1:0] period_next [TONE_REGS];
    logic [COUNT_W-1:0]  tone_cd_reg [TONE_REGS];
    logic [COUNT_W-1:0]  tone_cd_next[TONE_REGS];
    logic [TONE_REGS-1:0] tone_lvl_reg;
    logic [TONE_REGS-1:0] tone_lvl_next;
    logic [ATTEN_W-1:0]  atten_reg  [4];
    logic [ATTEN_W-1:0]  atten_next [4];
    logic [2:0]          nmode_reg, nmode_next;
    logic [LFSR_W-1:0]   lfsr_reg, lfsr_next;
    logic                nlvl_reg, nlvl_next;
    logic [COUNT_W-1:0]  ncd_reg, ncd_next;
    logic [2:0]          latch_reg, latch_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;

    logic [THRESH_W-1:0] thresh;
    logic                is_latch;
    logic [2:0]          wr_reg_sel;
    logic                lfsr_fb;
    logic [LFSR_W-1:0]   lfsr_shift;
    logic signed [SUM_W-1:0] rounded;
    logic signed [SUM_W-1:0] quot;

    assign thresh        = {rate_reg, 4'b0000};
    assign sts.mute      = (rate_reg == '0);
    assign sts.tick_due  = (acc_reg >= {{(ACC_W-THRESH_W){1'b0}}, thresh});
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign sample_value  = sample_reg;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= CHIP_CLOCK_RESET;
            rate_reg  <= SAMPLE_RATE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CHIP_CLOCK)
            begin
                clock_reg <= cfg_data[CLOCK_W-1:0];
            end
            else
            begin
                rate_reg <= cfg_data[RATE_W-1:0];
            end
        end
    end

    assign is_latch   = write_byte[7];
    assign wr_reg_sel = is_latch ? write_byte[6:4] : latch_reg;
    assign lfsr_fb    = nmode_reg[2] ? (lfsr_reg[0] ^ lfsr_reg[1]) : lfsr_reg[0];
    assign lfsr_shift = {lfsr_fb, lfsr_reg[LFSR_W-1:1]};

    // Bus writes and chip ticks
    always_comb
    begin
        for (int c = 0; c < TONE_REGS; c++)
        begin
            period_next[c]  = period_reg[c];
            tone_cd_next[c] = tone_cd_reg[c];
        end
        for (int a = 0; a < 4; a++)
        begin
            atten_next[a] = atten_reg[a];
        end
        tone_lvl_next = tone_lvl_reg;
        nmode_next    = nmode_reg;
        lfsr_next     = lfsr_reg;
        nlvl_next     = nlvl_reg;
        ncd_next      = ncd_reg;
        latch_next    = latch_reg;

        if (cmd.bus_write)
        begin
            if (is_latch)
            begin
                latch_next = write_byte[6:4];
            end
            if (wr_reg_sel == REG_NOISE_MODE)
            begin
                // Noise mode write restarts the shift register
                nmode_next = write_byte[2:0];
                lfsr_next  = LFSR_SEED;
                nlvl_next  = 1'b1;
                ncd_next   = noise_cd_load(write_byte[1:0], period_reg[2]);
            end
            else if (wr_reg_sel[0])
            begin
                for (int a = 0; a < 4; a++)
                begin
                    if (wr_reg_sel[2:1] == a[1:0])
                    begin
                        atten_next[a] = write_byte[3:0];
                    end
                end
            end
            else
            begin
                for (int c = 0; c < TONE_REGS; c++)
                begin
                    if (wr_reg_sel[2:1] == c[1:0])
                    begin
                        if (is_latch)
                        begin
                            period_next[c] = {period_reg[c][9:4], write_byte[3:0]};
                        end
                        else
                        begin
                            period_next[c] = {write_byte[5:0], period_reg[c][3:0]};
                        end
                    end
                end
            end
        end

        if (cmd.tick)
        begin
            for (int c = 0; c < TONE_REGS; c++)
            begin
                if (c < TONE_CHANNELS)
                begin
                    if (tone_cd_reg[c] > 11'd1)
                    begin
                        tone_cd_next[c] = tone_cd_reg[c] - 11'd1;
                    end
                    else
                    begin
                        tone_cd_next[c]  = period_or_max(period_reg[c]);
                        tone_lvl_next[c] = !tone_lvl_reg[c];
                    end
                end
            end
            if (ncd_reg > 11'd1)
            begin
                ncd_next = ncd_reg - 11'd1;
            end
            else
            begin
                ncd_next  = noise_cd_load(nmode_reg[1:0], period_reg[2]);
                lfsr_next = lfsr_shift;
                nlvl_next = lfsr_shift[0];
            end
        end
    end

    // Advance the rate accumulator
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_add)
        begin
            acc_next = acc_reg + {{(ACC_W-CLOCK_W){1'b0}}, clock_reg};
        end
        else if (cmd.tick)
        begin
            acc_next = acc_reg - {{(ACC_W-THRESH_W){1'b0}}, thresh};
        end
    end

    // Mix the channels, then divide by four toward zero
    always_comb
    begin
        logic signed [SUM_W-1:0] term;
        term     = '0;
        sum_next = '0;
        for (int c = 0; c < TONE_REGS; c++)
        begin
            if (c < TONE_CHANNELS)
            begin
                term     = signed'({{(SUM_W-LEVEL_W){1'b0}}, atten_level(atten_reg[c])});
                sum_next = tone_lvl_reg[c] ? (sum_next + term) : (sum_next - term);
            end
        end
        term     = signed'({{(SUM_W-LEVEL_W){1'b0}}, atten_level(atten_reg[3])});
        sum_next = nlvl_reg ? (sum_next + term) : (sum_next - term);
        if (sts.mute)
        begin
            sum_next = '0;
        end
    end

    assign rounded     = sum_reg + (sum_reg[SUM_W-1] ? 17'sd3 : 17'sd0);
    assign quot        = rounded >>> 2;
    assign sample_next = quot[SAMPLE_W-1:0];

    // Keep the output valid until the transfer completes
    assign out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < TONE_REGS; c++)
            begin
                period_reg[c]  <= '0;
                tone_cd_reg[c] <= TONE_CD_RESET;
            end
            for (int a = 0; a < 4; a++)
            begin
                atten_reg[a] <= 4'hf;
            end
            tone_lvl_reg  <= '1;
            nmode_reg     <= '0;
            lfsr_reg      <= LFSR_SEED;
            nlvl_reg      <= 1'b1;
            ncd_reg       <= noise_cd_load(2'd0, '0);
            latch_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < TONE_REGS; c++)
            begin
                period_reg[c]  <= period_next[c];
                tone_cd_reg[c] <= tone_cd_next[c];
            end
            for (int a = 0; a < 4; a++)
            begin
                atten_reg[a] <= atten_next[a];
            end
            tone_lvl_reg  <= tone_lvl_next;
            nmode_reg     <= nmode_next;
            lfsr_reg      <= lfsr_next;
            nlvl_reg      <= nlvl_next;
            ncd_reg       <= ncd_next;
            latch_reg     <= latch_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.mix)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.load_out)
        begin
            sample_reg <= sample_next;
        end
    end

`ifndef ASSERT_OFF
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("output valid raised without a load");

    a_acc_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mix && !sts.mute) |-> !sts.tick_due)
        else $error("mixing started with ticks still owed");

    a_mute_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mix && sts.mute) |=> (sum_reg == '0))
        else $error("muted sample did not mix to zero");
`endif

endmodule

`default_nettype wire
